>>> src/lurl_pkg.sv
// shared types, constants and helpers for the longest unique run length block
package lurl_pkg;

    // position counter width and table depth
    localparam int POS_BITS      = 16;
    localparam int ALPHABET_SIZE = 256;
    localparam int IDX_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 16;

    // result length limit on the output port
    localparam int OUT_MAX       = 65535;

    // one classified request as it travels from front to back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             present;
        logic             eos;
    } t_item;

    // bytes beyond the alphabet share the top table entry
    function automatic logic [IDX_W-1:0] to_index(input logic [BYTE_W-1:0] v);
        if ({1'b0, v} >= (BYTE_W + 1)'(ALPHABET_SIZE)) begin
            return IDX_W'(ALPHABET_SIZE - 1);
        end else begin
            return v[IDX_W-1:0];
        end
    endfunction

endpackage

>>> src/lurl_front.sv
// input side: takes requests, classifies them and queues them for the back end
module lurl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_byte_value,
    input  logic            i_byte_present,
    input  logic            i_end_of_string,
    output logic            o_head_valid,
    output lurl_pkg::t_item o_head,
    input  logic            i_pop
);
    import lurl_pkg::*;

    // depth is a power of two so the pointers wrap on their own
    localparam int QD = 2;
    localparam int QW = $clog2(QD);

    t_item           r_q [QD];
    logic [QW-1:0]   r_wp, n_wp;
    logic [QW-1:0]   r_rp, n_rp;
    logic [QW:0]     r_cnt, n_cnt;
    logic            accept;
    logic            push;
    logic            pop;
    t_item           item;

    assign o_stall      = (r_cnt == (QW + 1)'(QD));
    assign accept       = i_valid && !o_stall;
    // a request with no byte and no end mark changes nothing, so it is dropped
    assign push         = accept && (i_byte_present || i_end_of_string);
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        item.idx     = to_index(i_byte_value);
        item.present = i_byte_present;
        item.eos     = i_end_of_string;
    end

    always_comb begin
        n_wp  = push ? r_wp + QW'(1) : r_wp;
        n_rp  = pop  ? r_rp + QW'(1) : r_rp;
        n_cnt = r_cnt + (QW + 1)'(push) - (QW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

>>> src/lurl_back.sv
// execution side: last position table, window tracking and the result register
module lurl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  lurl_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_longest_length,
    output logic            o_length_saturated
);
    import lurl_pkg::*;

    localparam int PW1 = POS_BITS + 1;
    localparam int CMP_W = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [POS_BITS-1:0]      r_last_pos [ALPHABET_SIZE];
    logic [POS_BITS-1:0]      r_rd;
    logic [ALPHABET_SIZE-1:0] r_seen;
    logic                     r_s1_valid;
    t_item                    r_s1;
    logic [POS_BITS-1:0]      r_ws, n_ws;
    logic [POS_BITS-1:0]      r_pos, n_pos;
    logic [POS_BITS-1:0]      r_best, n_best;
    logic                     r_sat, n_sat;
    logic                     r_out_valid;
    logic [LEN_W-1:0]         r_out_len, n_out_len;
    logic                     r_out_sat, n_out_sat;

    logic                     go;
    logic                     fire;
    logic                     wr_en;
    logic                     hit;
    logic [PW1-1:0]           nxt;
    logic [PW1-1:0]           cur;
    logic                     cur_sat;
    logic [POS_BITS-1:0]      cur_c;
    logic [POS_BITS-1:0]      ws_hit;
    logic                     pos_at_max;
    logic [CMP_W-1:0]         best_wide;

    // hold the whole pipe only when a result is due and the slot is blocked
    assign go     = !(r_s1_valid && r_s1.eos && r_out_valid && i_stall);
    assign o_pop  = go && i_head_valid;
    assign fire   = r_s1_valid && go;
    assign wr_en  = fire && r_s1.present;

    always_comb begin
        hit        = r_seen[r_s1.idx] && (r_rd >= r_ws);
        nxt        = {1'b0, r_rd} + PW1'(1);
        ws_hit     = (nxt > {1'b0, r_pos}) ? r_pos : nxt[POS_BITS-1:0];
        n_ws       = hit ? ws_hit : r_ws;
        cur        = {1'b0, r_pos} - {1'b0, n_ws} + PW1'(1);
        cur_sat    = (cur > {1'b0, POS_MAX});
        cur_c      = cur_sat ? POS_MAX : cur[POS_BITS-1:0];
        n_best     = (cur_c > r_best) ? cur_c : r_best;
        pos_at_max = (r_pos == POS_MAX);
        n_pos      = pos_at_max ? r_pos : r_pos + POS_BITS'(1);
        n_sat      = r_sat || cur_sat || pos_at_max;
    end

    // result fields from the state as it stands after this request
    always_comb begin
        best_wide = r_s1.present ? CMP_W'(n_best) : CMP_W'(r_best);
        n_out_sat = r_s1.present ? n_sat : r_sat;
        if (best_wide > CMP_W'(OUT_MAX)) begin
            n_out_len = LEN_W'(OUT_MAX);
            n_out_sat = 1'b1;
        end else begin
            n_out_len = best_wide[LEN_W-1:0];
        end
    end

    // table read with bypass of the write made at the same edge
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_last_pos[r_s1.idx] <= r_pos;
        end
        if (go) begin
            if (wr_en && (r_s1.idx == i_head.idx)) begin
                r_rd <= r_pos;
            end else begin
                r_rd <= r_last_pos[i_head.idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_seen     <= '0;
            r_ws       <= '0;
            r_pos      <= '0;
            r_best     <= '0;
            r_sat      <= 1'b0;
        end else begin
            if (go) begin
                r_s1_valid <= o_pop;
            end
            if (fire) begin
                if (r_s1.eos) begin
                    r_seen <= '0;
                    r_ws   <= '0;
                    r_pos  <= '0;
                    r_best <= '0;
                    r_sat  <= 1'b0;
                end else if (r_s1.present) begin
                    r_seen[r_s1.idx] <= 1'b1;
                    r_ws             <= n_ws;
                    r_pos            <= n_pos;
                    r_best           <= n_best;
                    r_sat            <= n_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1 <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_s1.eos) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_s1.eos) begin
            r_out_len <= n_out_len;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_longest_length   = r_out_len;
    assign o_length_saturated = r_out_sat;

    a_ws_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ws <= r_pos)
        else $error("window start passed the position");

    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_s1.eos |=> (r_seen == '0) && (r_pos == '0) && (r_best == '0))
        else $error("string state not cleared after end");

    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_s1.eos |=> r_best >= $past(r_best))
        else $error("best length went down inside a string");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out_len))
        else $error("pending result overwritten");

endmodule

>>> src/longest_unique_run_length_core.sv
// top level of the longest unique run length block
//
// input channel: i_valid / o_stall carry one request per byte, with
// i_byte_value, i_byte_present and i_end_of_string; a request is taken at
// a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry one result per string, with
// o_longest_length and o_length_saturated
// a request with end_of_string set closes the string and yields one result;
// one with neither a byte nor the end mark is taken and dropped
// one request per cycle while not held, set by the last position table loop
// (registered read with a bypass for a byte that repeats right away)
// an end request goes from the queue through the stage register to o_valid
// reset (synchronous, active low) empties the queue and result slot and clears
// the seen flags at once; no clearing pass, so requests are taken right after
// receiver stall: the result register holds; the back end keeps running until
// the next end request, then the two entry queue fills and o_stall rises
module longest_unique_run_length_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_byte_present,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_longest_length,
    output logic        o_length_saturated
);
    import lurl_pkg::*;

    // queue head as seen by the back end
    logic  head_valid;
    t_item head;
    logic  pop;

    // front: accept, map byte to table index, drop empty requests, queue
    lurl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_byte_value    (i_byte_value),
        .i_byte_present  (i_byte_present),
        .i_end_of_string (i_end_of_string),
        .o_head_valid    (head_valid),
        .o_head          (head),
        .i_pop           (pop)
    );

    // back: table lookup, window update and result register
    lurl_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head_valid       (head_valid),
        .i_head             (head),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_longest_length   (o_longest_length),
        .o_length_saturated (o_length_saturated)
    );

endmodule
